/* hw/rtl/basic_source_tokenizer_defines.svh */
// assertion macros for the source tokenizer
// used by the top level only
`ifndef BASIC_SOURCE_TOKENIZER_DEFINES_SVH
`define BASIC_SOURCE_TOKENIZER_DEFINES_SVH
// property that holds outside reset
`define BST_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// condition that never holds outside reset
`define BST_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`endif

/* hw/rtl/bst_pkg.sv */
// shared types and constants of the source tokenizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bst_pkg;
   localparam int unsigned MAX_KEYWORD_LEN = 8;
   localparam int unsigned POS_BITS = 24;
   localparam int unsigned LINE_BITS = 20;
   localparam int unsigned KLEN_BITS = $clog2(MAX_KEYWORD_LEN + 1);
   localparam int unsigned WIDX_BITS = $clog2(MAX_KEYWORD_LEN);

   typedef enum logic [3:0] {
      M_IDLE, M_WORD, M_ZERO, M_NUM, M_STR, M_COMMENT, M_LT, M_GT, M_EQ, M_BANG, M_HALT
   } mode_type;

   typedef enum logic [1:0] {B_DEC, B_HEX, B_BIN} base_type;

   localparam logic [5:0] K_EOL = 6'd0, K_EOF = 6'd1, K_IDENT = 6'd2, K_INT = 6'd3,
      K_FLOAT = 6'd4, K_STRING = 6'd5, K_ADD = 6'd6, K_SUB = 6'd7, K_MUL = 6'd8,
      K_DIV = 6'd9, K_MOD = 6'd10, K_SHL = 6'd11, K_SHR = 6'd12, K_LT = 6'd13,
      K_LTEQ = 6'd14, K_GT = 6'd15, K_GTEQ = 6'd16, K_EQU = 6'd17, K_NEQU = 6'd18,
      K_DOT = 6'd21, K_COLON = 6'd22, K_PARL = 6'd23, K_PARR = 6'd24,
      K_ASSIGN = 6'd25, K_COMMA = 6'd26;

   localparam logic [2:0] E_NONE = 3'd0, E_CHAR = 3'd1, E_LIT = 3'd2,
      E_UNTERM = 3'd3, E_EMPTY = 3'd4;

   typedef struct packed {
      logic [7:0] src_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [5:0]           token_kind;
      logic [31:0]          literal_value;
      logic [3:0]           frac_digits;
      logic [POS_BITS-1:0]  start_offset;
      logic [POS_BITS-1:0]  text_length;
      logic [LINE_BITS-1:0] line_number;
      logic [2:0]           error_code;
      logic                 last_of_run;
   } rsp_type;

   // keyword lookup over a zero-padded word buffer
   function automatic logic [5:0] keyword_kind(input logic [8*MAX_KEYWORD_LEN-1:0] w,
                                                input logic [KLEN_BITS-1:0] n);
      logic [63:0] s;
      logic [5:0]  k;
      begin
         s = 64'(w);
         k = K_IDENT;
         case (n)
            4'd2: case (s[15:0])
               "ro": k = 6'd20;  "fi": k = 6'd35;
               default: k = K_IDENT;
            endcase
            4'd3: case (s[23:0])
               "dna": k = 6'd19; "dne": k = 6'd32; "rof": k = 6'd38; "wen": k = 6'd43;
               default: k = K_IDENT;
            endcase
            4'd4: case (s[31:0])
               "epyt": k = 6'd29; "eurt": k = 6'd33; "esle": k = 6'd36;
               default: k = K_IDENT;
            endcase
            4'd5: case (s[39:0])
               "lacol": k = 6'd28; "eslaf": k = 6'd34; "elihw": k = 6'd37;
               "kaerb": k = 6'd39; "evael": k = 6'd42;
               default: k = K_IDENT;
            endcase
            4'd6: case (s[47:0])
               "labolg": k = 6'd27; "nruter": k = 6'd41;
               default: k = K_IDENT;
            endcase
            4'd8: case (s)
               "noitcnuf": k = 6'd30; "lanretxe": k = 6'd31; "eunitnoc": k = 6'd40;
               default: k = K_IDENT;
            endcase
            default: k = K_IDENT;
         endcase
         return k;
      end
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/bst_fifo.sv */
// eight-entry result queue that takes up to four items per cycle
// depends on bst_pkg
`timescale 1ns / 1ps
`default_nettype none
module bst_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [2:0]        wr_count,
   input  bst_pkg::rsp_type       wr_data [4],
   output logic                   room,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bst_pkg::rsp_type       rsp_data
);
   import bst_pkg::*;
   rsp_type    mem_ff [8];
   logic [2:0] rd_ff, wr_ff;
   logic [3:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop = rsp_valid && rsp_ready;
   assign rsp_valid = cnt_ff != 4'd0;
   assign rsp_data = mem_ff[rd_ff];
   // a burst of four fits whenever at most four are queued
   assign room = cnt_ff <= 4'd4;
   assign cnt_in = cnt_ff + {1'b0, wr_count} - {3'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_ff + {2'b0, pop};
         wr_ff <= wr_ff + wr_count;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < wr_count) mem_ff[wr_ff + 3'(i)] <= wr_data[i];
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/basic_source_tokenizer.sv */
// Source tokenizer: one source byte per cycle, up to four tokens per byte into
// an eight-entry result queue. A byte is taken every cycle while at most four
// results are queued; the only stall is the queue filling when the consumer is
// slower. The tokens of each byte are formed combinationally and pass one register
// stage, the result queue, so they reach the output in the next cycle at earliest.
`timescale 1ns / 1ps
`default_nettype none
`include "basic_source_tokenizer_defines.svh"
module basic_source_tokenizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  bst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output bst_pkg::rsp_type rsp_data
);
   import bst_pkg::*;

   mode_type                 mode_ff, mode_in;
   logic [7:0]               wbuf_ff [MAX_KEYWORD_LEN];
   logic [7:0]               wbuf_in [MAX_KEYWORD_LEN];
   logic [POS_BITS-1:0]      wlen_ff, wlen_in;
   logic [31:0]              acc_ff, acc_in;
   base_type                 base_ff, base_in;
   logic [3:0]               frac_ff, frac_in;
   logic                     point_ff, point_in;
   logic [POS_BITS-1:0]      pos_ff, pos_in, tstart_ff, tstart_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   logic                     room, take;
   rsp_type                  slot [4];
   logic [2:0]               n;
   logic                     take_mid, take_end, bad_err;

   assign req_ready = room;
   assign take = req_valid && req_ready;

   function automatic logic is_word(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction
   function automatic logic is_dig(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   always_comb begin
      logic [7:0] b;
      logic [LINE_BITS-1:0] ln;
      logic [4:0] d;
      logic rescan, fin;
      logic [8*MAX_KEYWORD_LEN-1:0] w;
      logic [KLEN_BITS-1:0] wl;
      b = req_data.src_byte;
      mode_in = mode_ff; wbuf_in = wbuf_ff; wlen_in = wlen_ff; acc_in = acc_ff;
      base_in = base_ff; frac_in = frac_ff; point_in = point_ff; pos_in = pos_ff;
      tstart_in = tstart_ff; line_in = line_ff;
      n = '0; ln = line_ff; rescan = 1'b0; fin = 1'b0; d = 5'd31;
      for (int i = 0; i < 4; i++) slot[i] = '0;
      for (int i = 0; i < MAX_KEYWORD_LEN; i++)
         w[8*i +: 8] = (POS_BITS'(i) < wlen_ff) ? wbuf_ff[i] : 8'd0;
      wl = (wlen_ff <= POS_BITS'(MAX_KEYWORD_LEN)) ? KLEN_BITS'(wlen_ff) : '0;

      // digit value in the current base, 31 when none
      if (base_ff == B_BIN) begin
         if (b == "0" || b == "1") d = 5'(b - "0");
      end else if (is_dig(b)) d = 5'(b - "0");
      else if (base_ff == B_HEX && b >= "a" && b <= "f") d = 5'(b - "a" + 8'd10);
      else if (base_ff == B_HEX && b >= "A" && b <= "F") d = 5'(b - "A" + 8'd10);

      if (b == 8'd0) fin = 1'b1;
      else begin
         pos_in = pos_ff + 1'b1;
         fin = req_data.end_of_stream;
         rescan = 1'b0;
         unique case (mode_ff)
            M_WORD: begin
               if (is_word(b) || is_dig(b)) begin
                  if (wlen_ff < POS_BITS'(MAX_KEYWORD_LEN))
                     wbuf_in[wlen_ff[WIDX_BITS-1:0]] = b;
                  if (wlen_ff != '1) wlen_in = wlen_ff + 1'b1;
               end else begin
                  slot[n[1:0]].token_kind = keyword_kind(w, wl);
                  if (slot[n[1:0]].token_kind == K_IDENT) slot[n[1:0]].text_length = wlen_ff;
                  slot[n[1:0]].start_offset = tstart_ff; slot[n[1:0]].line_number = ln;
                  n = n + 1'b1; mode_in = M_IDLE; rescan = 1'b1;
               end
            end
            M_ZERO, M_NUM: begin
               if (mode_ff == M_ZERO && (b == "x" || b == "b")) begin
                  mode_in = M_NUM; base_in = (b == "x") ? B_HEX : B_BIN;
               end else if (b == "." && mode_ff == M_NUM && (base_ff != B_DEC || point_ff)) begin
                  slot[n[1:0]].token_kind = K_EOF; slot[n[1:0]].error_code = E_LIT;
                  slot[n[1:0]].start_offset = pos_ff; slot[n[1:0]].line_number = ln;
                  n = n + 1'b1; mode_in = M_HALT;
               end else if (b == ".") begin
                  mode_in = M_NUM; point_in = 1'b1;
               end else if (d != 5'd31) begin
                  mode_in = M_NUM;
                  unique case (base_ff)
                     B_HEX: acc_in = {acc_ff[27:0], 4'd0} + 32'(d);
                     B_BIN: acc_in = {acc_ff[30:0], 1'b0} + 32'(d);
                     default: acc_in = {acc_ff[28:0], 3'd0} + {acc_ff[30:0], 1'b0} + 32'(d);
                  endcase
                  if (point_ff && frac_ff != 4'd15) frac_in = frac_ff + 1'b1;
               end else begin
                  slot[n[1:0]].token_kind = point_ff ? K_FLOAT : K_INT;
                  slot[n[1:0]].literal_value = acc_ff;
                  slot[n[1:0]].frac_digits = point_ff ? frac_ff : 4'd0;
                  slot[n[1:0]].start_offset = tstart_ff; slot[n[1:0]].line_number = ln;
                  n = n + 1'b1; mode_in = M_IDLE; rescan = 1'b1;
               end
            end
            M_STR: begin
               if (b == 8'd10) begin
                  slot[n[1:0]].token_kind = K_EOF; slot[n[1:0]].error_code = E_UNTERM;
                  slot[n[1:0]].start_offset = pos_ff; slot[n[1:0]].line_number = ln;
                  n = n + 1'b1; mode_in = M_HALT;
               end else if (b == "\"") begin
                  if (wlen_ff == '0) begin
                     slot[n[1:0]].token_kind = K_EOF; slot[n[1:0]].error_code = E_EMPTY;
                     mode_in = M_HALT;
                  end else begin
                     slot[n[1:0]].token_kind = K_STRING; slot[n[1:0]].text_length = wlen_ff;
                     mode_in = M_IDLE;
                  end
                  slot[n[1:0]].start_offset = tstart_ff; slot[n[1:0]].line_number = ln;
                  n = n + 1'b1;
               end else if (wlen_ff != '1) wlen_in = wlen_ff + 1'b1;
            end
            M_COMMENT: begin
               if (b == 8'd10) begin
                  slot[n[1:0]].token_kind = K_EOL; slot[n[1:0]].start_offset = pos_ff;
                  slot[n[1:0]].line_number = ln; n = n + 1'b1;
                  ln = ln + 1'b1; mode_in = M_IDLE;
               end
            end
            M_LT, M_GT, M_EQ: begin
               mode_in = M_IDLE;
               slot[n[1:0]].start_offset = tstart_ff; slot[n[1:0]].line_number = ln;
               if (b == "=")
                  slot[n[1:0]].token_kind = (mode_ff == M_LT) ? K_LTEQ :
                                            (mode_ff == M_GT) ? K_GTEQ : K_EQU;
               else if (mode_ff == M_LT && b == "<") slot[n[1:0]].token_kind = K_SHL;
               else if (mode_ff == M_GT && b == ">") slot[n[1:0]].token_kind = K_SHR;
               else begin
                  slot[n[1:0]].token_kind = (mode_ff == M_LT) ? K_LT :
                                            (mode_ff == M_GT) ? K_GT : K_ASSIGN;
                  rescan = 1'b1;
               end
               n = n + 1'b1;
            end
            M_BANG: begin
               slot[n[1:0]].start_offset = tstart_ff; slot[n[1:0]].line_number = ln;
               if (b == "=") begin
                  slot[n[1:0]].token_kind = K_NEQU; mode_in = M_IDLE;
               end else begin
                  slot[n[1:0]].token_kind = K_EOF; slot[n[1:0]].error_code = E_CHAR;
                  mode_in = M_HALT;
               end
               n = n + 1'b1;
            end
            M_IDLE: rescan = 1'b1;
            default: rescan = 1'b0;
         endcase

         if (rescan) begin
            slot[n[1:0]].start_offset = pos_ff; slot[n[1:0]].line_number = ln;
            case (b)
               " ", 8'd9, 8'd13: ;
               8'd10: begin
                  slot[n[1:0]].token_kind = K_EOL; n = n + 1'b1; ln = ln + 1'b1;
               end
               "\"": begin
                  mode_in = M_STR; wlen_in = '0; tstart_in = pos_ff + 1'b1;
               end
               ";": mode_in = M_COMMENT;
               "<": begin mode_in = M_LT; tstart_in = pos_ff; end
               ">": begin mode_in = M_GT; tstart_in = pos_ff; end
               "=": begin mode_in = M_EQ; tstart_in = pos_ff; end
               "!": begin mode_in = M_BANG; tstart_in = pos_ff; end
               "+": begin slot[n[1:0]].token_kind = K_ADD; n = n + 1'b1; end
               "-": begin slot[n[1:0]].token_kind = K_SUB; n = n + 1'b1; end
               "*": begin slot[n[1:0]].token_kind = K_MUL; n = n + 1'b1; end
               "/": begin slot[n[1:0]].token_kind = K_DIV; n = n + 1'b1; end
               "%": begin slot[n[1:0]].token_kind = K_MOD; n = n + 1'b1; end
               ".": begin slot[n[1:0]].token_kind = K_DOT; n = n + 1'b1; end
               ":": begin slot[n[1:0]].token_kind = K_COLON; n = n + 1'b1; end
               "(": begin slot[n[1:0]].token_kind = K_PARL; n = n + 1'b1; end
               ")": begin slot[n[1:0]].token_kind = K_PARR; n = n + 1'b1; end
               ",": begin slot[n[1:0]].token_kind = K_COMMA; n = n + 1'b1; end
               default: begin
                  if (is_word(b)) begin
                     mode_in = M_WORD; tstart_in = pos_ff; wbuf_in[0] = b;
                     wlen_in = POS_BITS'(1);
                  end else if (is_dig(b)) begin
                     mode_in = (b == "0") ? M_ZERO : M_NUM; tstart_in = pos_ff;
                     acc_in = 32'(b - "0"); base_in = B_DEC; point_in = 1'b0;
                     frac_in = '0;
                  end else begin
                     slot[n[1:0]].token_kind = K_EOF; slot[n[1:0]].error_code = E_CHAR;
                     n = n + 1'b1; mode_in = M_HALT;
                  end
               end
            endcase
         end
      end

      if (fin) begin
         // flush the pending token, as it stands after this byte
         slot[n[1:0]].start_offset = tstart_in; slot[n[1:0]].line_number = ln;
         unique case (mode_in)
            M_WORD: begin
               for (int i = 0; i < MAX_KEYWORD_LEN; i++)
                  w[8*i +: 8] = (POS_BITS'(i) < wlen_in) ? wbuf_in[i] : 8'd0;
               wl = (wlen_in <= POS_BITS'(MAX_KEYWORD_LEN)) ? KLEN_BITS'(wlen_in) : '0;
               slot[n[1:0]].token_kind = keyword_kind(w, wl);
               if (slot[n[1:0]].token_kind == K_IDENT) slot[n[1:0]].text_length = wlen_in;
               n = n + 1'b1;
            end
            M_ZERO, M_NUM: begin
               slot[n[1:0]].token_kind = point_in ? K_FLOAT : K_INT;
               slot[n[1:0]].literal_value = acc_in;
               slot[n[1:0]].frac_digits = point_in ? frac_in : 4'd0;
               n = n + 1'b1;
            end
            M_STR: begin
               slot[n[1:0]].token_kind = K_EOF; slot[n[1:0]].error_code = E_UNTERM;
               n = n + 1'b1;
            end
            M_LT: begin slot[n[1:0]].token_kind = K_LT; n = n + 1'b1; end
            M_GT: begin slot[n[1:0]].token_kind = K_GT; n = n + 1'b1; end
            M_EQ: begin slot[n[1:0]].token_kind = K_ASSIGN; n = n + 1'b1; end
            M_BANG: begin
               slot[n[1:0]].token_kind = K_EOF; slot[n[1:0]].error_code = E_CHAR;
               n = n + 1'b1;
            end
            default: ;
         endcase
         if (mode_in != M_HALT && mode_in != M_STR && mode_in != M_BANG) begin
            slot[n[1:0]].token_kind = K_EOL; slot[n[1:0]].start_offset = pos_in;
            slot[n[1:0]].line_number = ln; n = n + 1'b1;
            slot[n[1:0]].token_kind = K_EOF; slot[n[1:0]].start_offset = pos_in;
            slot[n[1:0]].line_number = ln; n = n + 1'b1;
         end
         mode_in = M_IDLE; wlen_in = '0; acc_in = '0; base_in = B_DEC; frac_in = '0;
         point_in = 1'b0; pos_in = '0; tstart_in = '0; line_in = '0;
      end else line_in = ln;
      if (n != 3'd0) slot[2'(n - 1'b1)].last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE; wlen_ff <= '0; acc_ff <= '0; base_ff <= B_DEC;
         frac_ff <= '0; point_ff <= 1'b0; pos_ff <= '0; tstart_ff <= '0; line_ff <= '0;
      end else if (take) begin
         mode_ff <= mode_in; wlen_ff <= wlen_in; acc_ff <= acc_in; base_ff <= base_in;
         frac_ff <= frac_in; point_ff <= point_in; pos_ff <= pos_in;
         tstart_ff <= tstart_in; line_ff <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) wbuf_ff <= wbuf_in;
   end

   bst_fifo u_fifo (
      .clock(clock), .reset(reset), .wr_count(take ? n : 3'd0), .wr_data(slot),
      .room(room), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   assign take_mid = take && req_data.src_byte != 8'd0 && !req_data.end_of_stream;
   assign take_end = take && req_data.src_byte == 8'd0;
   assign bad_err = rsp_data.error_code != E_NONE && rsp_data.token_kind != K_EOF;

   `BST_ASSERT(a_halt_quiet, mode_ff == M_HALT && take_mid |=> mode_ff == M_HALT, "halt left early")
   `BST_NEVER(a_err_kind, rsp_valid && bad_err, "error without eof kind")
   `BST_ASSERT(a_end_clears, take_end |=> pos_ff == '0 && mode_ff == M_IDLE, "end did not clear")
endmodule
`default_nettype wire

/* sim/basic_source_tokenizer_tb.sv */
// testbench for the byte-serial source tokenizer: directed and random source text,
// token prediction in a scoreboard class, random idling on both channels
// depends on bst_pkg and basic_source_tokenizer
`timescale 1ns / 1ps
module basic_source_tokenizer_tb;
   import bst_pkg::*;

   class token_scoreboard;
      rsp_type   pending_tokens[$];
      int        mismatches;
      int        tokens_seen;
      int        bytes_seen;
      int        errors_seen;
      mode_type  mode;
      byte       word_buf[MAX_KEYWORD_LEN];
      bit [23:0] word_len;
      bit [31:0] acc;
      base_type  base;
      bit [3:0]  frac;
      bit        point;
      bit [23:0] pos;
      bit [23:0] tok_start;
      bit [19:0] line;
      int        burst;

      function void clear_stream();
         mode = M_IDLE;
         foreach (word_buf[i]) word_buf[i] = 0;
         word_len = 0;
         acc = 0;
         base = B_DEC;
         frac = 0;
         point = 0;
         pos = 0;
         tok_start = 0;
         line = 0;
      endfunction

      function void queue_token(bit [5:0] kind, bit [31:0] val, bit [3:0] fr,
                                bit [23:0] start, bit [23:0] len, bit [2:0] err);
         rsp_type t;
         if (burst >= 4) return;
         t.token_kind = kind;
         t.literal_value = val;
         t.frac_digits = fr;
         t.start_offset = start;
         t.text_length = len;
         t.line_number = line;
         t.error_code = err;
         t.last_of_run = 1'b0;
         pending_tokens.insert(pending_tokens.size(), t);
         burst++;
      endfunction

      function void halt_with(bit [2:0] err, bit [23:0] where);
         queue_token(K_EOF, 0, 0, where, 0, err);
         mode = M_HALT;
      endfunction

      function bit is_word_char(byte unsigned b);
         return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
      endfunction

      function int digit_value(byte unsigned b);
         if (base == B_BIN) return (b == "0" || b == "1") ? int'(b - "0") : -1;
         if (b >= "0" && b <= "9") return int'(b - "0");
         if (base == B_HEX) begin
            if (b >= "a" && b <= "f") return int'(b - "a" + 10);
            if (b >= "A" && b <= "F") return int'(b - "A" + 10);
         end
         return -1;
      endfunction

      function bit [5:0] word_kind();
         string s;
         s = "";
         if (word_len > MAX_KEYWORD_LEN) return K_IDENT;
         for (int i = 0; i < word_len; i++) s = {s, string'(word_buf[i])};
         case (s)
            "and": return 6'd19;      "or": return 6'd20;
            "global": return 6'd27;   "local": return 6'd28;
            "type": return 6'd29;     "function": return 6'd30;
            "external": return 6'd31; "end": return 6'd32;
            "true": return 6'd33;     "false": return 6'd34;
            "if": return 6'd35;       "else": return 6'd36;
            "while": return 6'd37;    "for": return 6'd38;
            "break": return 6'd39;    "continue": return 6'd40;
            "return": return 6'd41;   "leave": return 6'd42;
            "new": return 6'd43;
            default: return K_IDENT;
         endcase
      endfunction

      function void flush_word();
         bit [5:0] k;
         k = word_kind();
         queue_token(k, 0, 0, tok_start, (k == K_IDENT) ? word_len : 24'd0, E_NONE);
      endfunction

      function void flush_number();
         if (point) queue_token(K_FLOAT, acc, frac, tok_start, 0, E_NONE);
         else queue_token(K_INT, acc, 0, tok_start, 0, E_NONE);
      endfunction

      function void scan_fresh(byte unsigned b);
         case (b)
            " ", 8'h09, 8'h0d: return;
            8'h0a: begin
               queue_token(K_EOL, 0, 0, pos, 0, E_NONE);
               line++;
               return;
            end
            "\"": begin
               mode = M_STR;
               word_len = 0;
               tok_start = pos + 1;
               return;
            end
            ";": begin mode = M_COMMENT; return; end
            "<": begin mode = M_LT; tok_start = pos; return; end
            ">": begin mode = M_GT; tok_start = pos; return; end
            "=": begin mode = M_EQ; tok_start = pos; return; end
            "!": begin mode = M_BANG; tok_start = pos; return; end
            "+": begin queue_token(K_ADD, 0, 0, pos, 0, E_NONE); return; end
            "-": begin queue_token(K_SUB, 0, 0, pos, 0, E_NONE); return; end
            "*": begin queue_token(K_MUL, 0, 0, pos, 0, E_NONE); return; end
            "/": begin queue_token(K_DIV, 0, 0, pos, 0, E_NONE); return; end
            "%": begin queue_token(K_MOD, 0, 0, pos, 0, E_NONE); return; end
            ".": begin queue_token(K_DOT, 0, 0, pos, 0, E_NONE); return; end
            ":": begin queue_token(K_COLON, 0, 0, pos, 0, E_NONE); return; end
            "(": begin queue_token(K_PARL, 0, 0, pos, 0, E_NONE); return; end
            ")": begin queue_token(K_PARR, 0, 0, pos, 0, E_NONE); return; end
            ",": begin queue_token(K_COMMA, 0, 0, pos, 0, E_NONE); return; end
            default: ;
         endcase
         if (is_word_char(b)) begin
            mode = M_WORD;
            tok_start = pos;
            word_buf[0] = b;
            word_len = 1;
         end else if (b >= "0" && b <= "9") begin
            mode = (b == "0") ? M_ZERO : M_NUM;
            tok_start = pos;
            acc = b - "0";
            base = B_DEC;
            point = 0;
            frac = 0;
         end else begin
            halt_with(E_CHAR, pos);
         end
      endfunction

      // true when the byte belongs to the token in progress
      function bit scan_continue(byte unsigned b);
         int d;
         case (mode)
            M_WORD: begin
               if (is_word_char(b) || (b >= "0" && b <= "9")) begin
                  if (word_len < MAX_KEYWORD_LEN) word_buf[word_len] = b;
                  if (word_len != 24'hffffff) word_len++;
                  return 1;
               end
               flush_word();
               mode = M_IDLE;
               return 0;
            end
            M_ZERO: begin
               mode = M_NUM;
               if (b == "x") begin base = B_HEX; return 1; end
               if (b == "b") begin base = B_BIN; return 1; end
               return scan_continue(b);
            end
            M_NUM: begin
               if (b == ".") begin
                  if (base != B_DEC || point) halt_with(E_LIT, pos);
                  else point = 1;
                  return 1;
               end
               d = digit_value(b);
               if (d >= 0) begin
                  acc = acc * (base == B_HEX ? 16 : (base == B_BIN ? 2 : 10)) + d;
                  if (point && frac < 15) frac++;
                  return 1;
               end
               flush_number();
               mode = M_IDLE;
               return 0;
            end
            M_STR: begin
               if (b == 8'h0a) begin halt_with(E_UNTERM, pos); return 1; end
               if (b == "\"") begin
                  if (word_len == 0) halt_with(E_EMPTY, tok_start);
                  else begin
                     queue_token(K_STRING, 0, 0, tok_start, word_len, E_NONE);
                     mode = M_IDLE;
                  end
                  return 1;
               end
               if (word_len != 24'hffffff) word_len++;
               return 1;
            end
            M_COMMENT: begin
               if (b == 8'h0a) begin
                  queue_token(K_EOL, 0, 0, pos, 0, E_NONE);
                  line++;
                  mode = M_IDLE;
               end
               return 1;
            end
            M_LT, M_GT: begin
               bit lt;
               lt = (mode == M_LT);
               mode = M_IDLE;
               if (b == "=") begin
                  queue_token(lt ? K_LTEQ : K_GTEQ, 0, 0, tok_start, 0, E_NONE);
                  return 1;
               end
               if (b == (lt ? "<" : ">")) begin
                  queue_token(lt ? K_SHL : K_SHR, 0, 0, tok_start, 0, E_NONE);
                  return 1;
               end
               queue_token(lt ? K_LT : K_GT, 0, 0, tok_start, 0, E_NONE);
               return 0;
            end
            M_EQ: begin
               mode = M_IDLE;
               if (b == "=") begin
                  queue_token(K_EQU, 0, 0, tok_start, 0, E_NONE);
                  return 1;
               end
               queue_token(K_ASSIGN, 0, 0, tok_start, 0, E_NONE);
               return 0;
            end
            M_BANG: begin
               if (b == "=") begin
                  mode = M_IDLE;
                  queue_token(K_NEQU, 0, 0, tok_start, 0, E_NONE);
               end else halt_with(E_CHAR, tok_start);
               return 1;
            end
            M_IDLE: return 0;
            default: return 1;
         endcase
      endfunction

      function void end_stream();
         case (mode)
            M_WORD: flush_word();
            M_ZERO, M_NUM: flush_number();
            M_STR: halt_with(E_UNTERM, tok_start);
            M_LT: queue_token(K_LT, 0, 0, tok_start, 0, E_NONE);
            M_GT: queue_token(K_GT, 0, 0, tok_start, 0, E_NONE);
            M_EQ: queue_token(K_ASSIGN, 0, 0, tok_start, 0, E_NONE);
            M_BANG: halt_with(E_CHAR, tok_start);
            default: ;
         endcase
         if (mode != M_HALT) begin
            queue_token(K_EOL, 0, 0, pos, 0, E_NONE);
            queue_token(K_EOF, 0, 0, pos, 0, E_NONE);
         end
         clear_stream();
      endfunction

      function void note_byte(req_type r);
         int first;
         first = pending_tokens.size();
         burst = 0;
         bytes_seen++;
         if (r.src_byte == 0) end_stream();
         else begin
            if (mode != M_HALT && !scan_continue(r.src_byte)) scan_fresh(r.src_byte);
            pos++;
            if (r.end_of_stream) end_stream();
         end
         if (pending_tokens.size() > first)
            pending_tokens[pending_tokens.size() - 1].last_of_run = 1'b1;
      endfunction

      function void check_token(rsp_type got);
         rsp_type want;
         tokens_seen++;
         if (got.error_code != E_NONE) errors_seen++;
         if (pending_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected token %p", got);
            return;
         end
         want = pending_tokens.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("token mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   token_scoreboard sb;
   int  send_idle_pct;
   int  recv_stall_pct;
   int  hold_off_cycles;
   int  cycle_count;
   int  random_bytes;

   basic_source_tokenizer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_token(rsp_data);
   end

   // valid stays high into the next item unless the sender idles
   task automatic send_byte(input byte unsigned b, input bit eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data.src_byte <= b;
      req_data.end_of_stream <= eos;
      do @(posedge clock); while (!req_ready);
      sb.note_byte('{src_byte: b, end_of_stream: eos});
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input bit eos);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], eos && i == s.len() - 1);
   endtask

   // random well-formed program fragment with occasional noise
   task automatic send_fragment();
      string pieces[] = '{"while", "if x1 >= 0x1F", "a_b<<3", "y>>b", "0b101",
         "12.500", "\"hi there\"", "; note\n", "\n", "q != 7", "c<=d", "e==f",
         "function", "continue", "externals", "and", "or", "(1,2):3", "Zz_9.", "%-*/+",
         "abcdefghij", "0x", "0b", "\t\r ", "3.14159265358979323", "4294967296", "new="};
      string s;
      int sel;
      s = pieces[$urandom_range(pieces.size() - 1)];
      sel = $urandom_range(99);
      if (sel < 90) send_text(s, 0);
      else send_byte(8'($urandom_range(255)), $urandom_range(1));
      send_byte(" ", 0);
      random_bytes += s.len() + 1;
   endtask

   task automatic random_phase(input int idle_pct, input int stall_pct, input int n);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      random_bytes = 0;
      while (random_bytes < n) begin
         send_fragment();
         if ($urandom_range(9) == 0) begin
            send_byte(8'h00, 0);
            random_bytes++;
         end
      end
      send_byte("x", 1);
   endtask

   initial begin
      sb = new();
      sb.clear_stream();
      sb.mismatches = 0;
      cycle_count = 0;
      hold_off_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed: operators, keywords, numbers, strings, errors at end
      send_text("if a<=0xFf>>b!=1.25;c\n", 0);
      send_byte(8'h00, 0);
      send_text("\"\"", 1);
      send_text("!x\"ab\n", 1);
      send_text("1..2", 0);
      send_byte(8'hff, 1);
      send_text("\"open", 1);
      send_text("!", 1);

      // long hold-off so the output queue fills and input stalls
      hold_off_cycles = 60;
      send_text("+-*/%<>=(,).", 0);
      send_byte(8'h00, 0);

      random_phase(0, 0, 25);
      random_phase(48, 0, 25);
      random_phase(0, 48, 25);
      random_phase(36, 36, 25);
      req_valid <= 1'b0;

      recv_stall_pct = 0;
      while (sb.pending_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("tokenized %0d bytes into %0d tokens, %0d of them errors",
               sb.bytes_seen, sb.tokens_seen, sb.errors_seen);
      $display("mismatches: %0d, tokens still expected: %0d",
               sb.mismatches, sb.pending_tokens.size());
      if (sb.mismatches == 0 && sb.pending_tokens.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
